// ===== rtl/fbsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbsa_pkg
// Shared types, codes and helpers of the flash bank slot allocator.
// ----------------------------------------------------------------------------
package fbsa_pkg;

  localparam int SlotCount = 4;
  localparam int SlotIdxW  = $clog2(SlotCount);
  localparam int BaseW     = 24;
  localparam int CntW      = $clog2(SlotCount + 1);
  localparam int StatesW   = 2 * SlotCount;
  localparam int InDataW   = 40;
  localparam int OutDataW  = 48;
  localparam int CfgIdxW   = 1;

  localparam int                NativeShift   = 18;  // stride 0x040000
  localparam logic [BaseW-1:0]  RegionBaseRst = 24'h3C0000;
  localparam logic [BaseW-1:0]  HalfOffsetRst = 24'h080000;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_LOAD       = 3'd1,
    OP_NATIVE     = 3'd2,
    OP_PLACE_AT   = 3'd3,
    OP_FIRST_FIT  = 3'd4,
    OP_FREE       = 3'd5,
    OP_FIND_RUN   = 3'd6,
    OP_READ       = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    SS_FREE   = 2'd0,
    SS_NATIVE = 2'd1,
    SS_ANCHOR = 2'd2,
    SS_SHADOW = 2'd3
  } slot_state_e;

  typedef enum logic [1:0] {
    SZ_256K = 2'd0,
    SZ_512K = 2'd1,
    SZ_1M   = 2'd2,
    SZ_ODD  = 2'd3
  } slot_size_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REGION_BASE = 1'b0,
    CFG_HALF_OFFSET = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    UM_SCAN  = 2'd0,
    UM_EVICT = 2'd1,
    UM_RANGE = 2'd2
  } unit_mode_e;

  typedef enum logic [2:0] {
    TB_NONE   = 3'd0,
    TB_CLEAR  = 3'd1,
    TB_LOAD   = 3'd2,
    TB_NATIVE = 3'd3,
    TB_PLACE  = 3'd4,
    TB_WIPE   = 3'd5
  } tbl_op_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [SlotIdxW-1:0] slot;
    slot_size_e          size;
    slot_state_e         state;
    logic [BaseW-1:0]    base;
  } item_t;

  typedef struct packed {
    tbl_op_e              op;
    logic [SlotIdxW-1:0]  slot;
    slot_size_e           size;
    slot_state_e          state;
    logic [BaseW-1:0]     base;
    logic [SlotCount-1:0] mask;
    logic [2:0]           need;
  } tbl_cmd_t;

  typedef struct packed {
    logic [SlotCount-1:0] wipe;
    logic [2:0]           run;
    logic                 hit;
    logic [SlotIdxW-1:0]  pos;
  } unit_res_t;

  typedef struct packed {
    logic                ok;
    logic [SlotIdxW-1:0] chosen;
    logic                base_valid;
  } seq_res_t;

  function automatic logic [2:0] span_of(slot_size_e sz);
    logic [2:0] span;
    unique case (sz)
      SZ_1M:   span = 3'd4;
      SZ_512K: span = 3'd2;
      SZ_256K: span = 3'd1;
      SZ_ODD:  span = 3'd1;
    endcase
    return span;
  endfunction

  function automatic logic [BaseW-1:0] native_base(logic [SlotIdxW-1:0] slot);
    return BaseW'(slot) << NativeShift;
  endfunction

  function automatic slot_state_e slot_state_at(logic [StatesW-1:0] v,
                                                logic [SlotIdxW-1:0] i);
    return slot_state_e'(v[2*i +: 2]);
  endfunction

  function automatic slot_size_e slot_size_at(logic [StatesW-1:0] v,
                                              logic [SlotIdxW-1:0] i);
    return slot_size_e'(v[2*i +: 2]);
  endfunction

  function automatic logic [CntW-1:0] count_free(logic [StatesW-1:0] v);
    logic [CntW-1:0] n;
    n = '0;
    for (int j = 0; j < SlotCount; j++) begin
      if (v[2*j +: 2] == SS_FREE) begin
        n = n + CntW'(1);
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/fbsa_table.sv =====
// ----------------------------------------------------------------------------
// fbsa_table
// Slot table: state, size code and base of every slot, updated by one
// command per cycle.
// ----------------------------------------------------------------------------
module fbsa_table import fbsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbl_cmd_t            cmd_i,
  input  logic [SlotIdxW-1:0] rd_addr_i,
  output logic [StatesW-1:0]  states_o,
  output logic [StatesW-1:0]  sizes_o,
  output logic [BaseW-1:0]    rd_base_o
);

  slot_state_e      state_q [SlotCount];
  slot_state_e      state_d [SlotCount];
  slot_size_e       size_q  [SlotCount];
  slot_size_e       size_d  [SlotCount];
  logic [BaseW-1:0] base_q  [SlotCount];
  logic [BaseW-1:0] base_d  [SlotCount];

  always_comb begin
    for (int j = 0; j < SlotCount; j++) begin
      state_d[j] = state_q[j];
      size_d[j]  = size_q[j];
      base_d[j]  = base_q[j];
    end
    unique case (cmd_i.op)
      TB_CLEAR: begin
        for (int j = 0; j < SlotCount; j++) begin
          state_d[j] = SS_FREE;
          size_d[j]  = SZ_256K;
          base_d[j]  = '0;
        end
      end
      TB_LOAD: begin
        state_d[cmd_i.slot] = cmd_i.state;
        if (cmd_i.state == SS_NATIVE) begin
          size_d[cmd_i.slot] = SZ_256K;
          base_d[cmd_i.slot] = native_base(cmd_i.slot);
        end else begin
          size_d[cmd_i.slot] = cmd_i.size;
          base_d[cmd_i.slot] = cmd_i.base;
        end
      end
      TB_NATIVE: begin
        state_d[cmd_i.slot] = SS_NATIVE;
        size_d[cmd_i.slot]  = SZ_256K;
        base_d[cmd_i.slot]  = native_base(cmd_i.slot);
      end
      TB_PLACE: begin
        for (int j = 0; j < SlotCount; j++) begin
          if (cmd_i.mask[j]) begin
            state_d[j] = SS_FREE;
            size_d[j]  = SZ_256K;
            base_d[j]  = '0;
          end
          if (3'(j) == 3'(cmd_i.slot)) begin
            state_d[j] = SS_ANCHOR;
            size_d[j]  = cmd_i.size;
            base_d[j]  = cmd_i.base;
          end else if (3'(j) > 3'(cmd_i.slot) &&
                       3'(j) < 3'(cmd_i.slot) + cmd_i.need) begin
            state_d[j] = SS_SHADOW;
            size_d[j]  = SZ_256K;
            base_d[j]  = '0;
          end
        end
      end
      TB_WIPE: begin
        for (int j = 0; j < SlotCount; j++) begin
          if (cmd_i.mask[j]) begin
            state_d[j] = SS_FREE;
            size_d[j]  = SZ_256K;
            base_d[j]  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SlotCount; j++) begin
        state_q[j] <= SS_FREE;
        size_q[j]  <= SZ_256K;
        base_q[j]  <= '0;
      end
    end else begin
      for (int j = 0; j < SlotCount; j++) begin
        state_q[j] <= state_d[j];
        size_q[j]  <= size_d[j];
        base_q[j]  <= base_d[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < SlotCount; j++) begin
      states_o[2*j +: 2] = state_q[j];
      sizes_o[2*j +: 2]  = size_q[j];
    end
  end

  assign rd_base_o = base_q[rd_addr_i];

endmodule

// ===== rtl/fbsa_unit.sv =====
// ----------------------------------------------------------------------------
// fbsa_unit
// Shared slot evaluator: examines the slot under the cursor for a free-run
// scan, an eviction pass or a range wipe.
// ----------------------------------------------------------------------------
module fbsa_unit import fbsa_pkg::*; (
  input  unit_mode_e          mode_i,
  input  logic [SlotIdxW-1:0] cursor_i,
  input  slot_state_e         cur_state_i,
  input  slot_size_e          cur_size_i,
  input  logic [SlotIdxW-1:0] at_i,
  input  logic [2:0]          need_i,
  input  logic [2:0]          run_i,
  input  logic                found_i,
  output unit_res_t           res_o
);

  logic [2:0] cur;
  logic [2:0] run_end;
  logic [2:0] anchor_end;
  logic       in_run;
  logic       overlap;
  logic       is_free;

  assign cur        = 3'(cursor_i);
  assign run_end    = 3'(at_i) + need_i;
  assign anchor_end = cur + span_of(cur_size_i);
  assign in_run     = (cur >= 3'(at_i)) && (cur < run_end);
  assign overlap    = (cur < run_end) && (3'(at_i) < anchor_end);
  assign is_free    = (cur_state_i == SS_FREE);

  always_comb begin
    res_o = '0;
    unique case (mode_i)
      UM_SCAN: begin
        res_o.run = is_free ? 3'(run_i + 3'd1) : 3'd0;
        res_o.hit = is_free && !found_i && (res_o.run == need_i);
        res_o.pos = SlotIdxW'(cur + 3'd1 - need_i);
      end
      UM_EVICT: begin
        if (cur_state_i == SS_ANCHOR && overlap) begin
          for (int j = 0; j < SlotCount; j++) begin
            res_o.wipe[j] = (3'(j) >= cur) && (3'(j) < anchor_end);
          end
        end else if (cur_state_i == SS_NATIVE && in_run) begin
          res_o.wipe[cursor_i] = 1'b1;
        end
      end
      UM_RANGE: begin
        res_o.wipe[cursor_i] = in_run;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/fbsa_seq.sv =====
// ----------------------------------------------------------------------------
// fbsa_seq
// Operation sequencer: walks the slots through the shared evaluator,
// checks placements, tries first-fit candidates and issues table updates.
// ----------------------------------------------------------------------------
module fbsa_seq import fbsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  item_t               item_i,
  output logic                ready_o,
  input  logic [StatesW-1:0]  states_i,
  input  logic [StatesW-1:0]  sizes_i,
  input  logic [BaseW-1:0]    region_base_i,
  input  logic [BaseW-1:0]    half_offset_i,
  output tbl_cmd_t            cmd_o,
  output logic                done_o,
  output seq_res_t            res_o,
  input  logic                take_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_WALK  = 6'b000100,
    S_CHECK = 6'b001000,
    S_APPLY = 6'b010000,
    S_DONE  = 6'b100000
  } seq_state_e;

  seq_state_e           state_q, state_d;
  item_t                item_q, item_d;
  unit_mode_e           mode_q, mode_d;
  logic [SlotIdxW-1:0]  cursor_q, cursor_d;
  logic [SlotIdxW-1:0]  at_q, at_d;
  logic [2:0]           need_q, need_d;
  logic [2:0]           run_q, run_d;
  logic [SlotCount-1:0] mask_q, mask_d;
  logic                 ok_q, ok_d;
  logic [SlotIdxW-1:0]  chosen_q, chosen_d;

  slot_state_e          cur_state;
  slot_size_e           cur_size;
  unit_res_t            unit_res;
  slot_state_e          tgt_state;
  slot_size_e           tgt_size;
  logic [2:0]           span_sz;
  logic                 size_ok;
  logic                 aligned;
  logic [3:0]           next_at;
  logic                 more;
  logic [SlotCount-1:0] occ;
  logic [SlotCount-1:0] rmask;
  logic                 place_ok;
  logic [BaseW-1:0]     place_base;

  assign cur_state = mask_q[cursor_q] ? SS_FREE : slot_state_at(states_i, cursor_q);
  assign cur_size  = slot_size_at(sizes_i, cursor_q);
  assign tgt_state = slot_state_at(states_i, item_q.slot);
  assign tgt_size  = slot_size_at(sizes_i, item_q.slot);
  assign span_sz   = span_of(item_q.size);
  assign size_ok   = (item_q.size == SZ_512K) || (item_q.size == SZ_1M);
  assign aligned   = (4'(item_q.slot) + 4'(span_sz) <= 4'(SlotCount)) &&
                     !(item_q.size == SZ_512K && item_q.slot[0]) &&
                     !(item_q.size == SZ_1M && item_q.slot != '0);
  assign next_at   = 4'(at_q) + 4'(need_q);
  assign more      = (next_at + 4'(need_q)) <= 4'(SlotCount);

  always_comb begin
    for (int j = 0; j < SlotCount; j++) begin
      occ[j]   = (slot_state_at(states_i, SlotIdxW'(j)) != SS_FREE) && !mask_q[j];
      rmask[j] = (4'(j) >= 4'(at_q)) && (4'(j) < next_at);
    end
  end

  assign place_ok   = ((occ & rmask) == '0) && (item_q.size != SZ_1M || occ == '0);
  assign place_base = (item_q.size == SZ_512K && at_q[1]) ?
                      BaseW'(region_base_i + half_offset_i) : region_base_i;

  fbsa_unit u_unit (
    .mode_i      (mode_q),
    .cursor_i    (cursor_q),
    .cur_state_i (cur_state),
    .cur_size_i  (cur_size),
    .at_i        (at_q),
    .need_i      (need_q),
    .run_i       (run_q),
    .found_i     (ok_q),
    .res_o       (unit_res)
  );

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    mode_d   = mode_q;
    cursor_d = cursor_q;
    at_d     = at_q;
    need_d   = need_q;
    run_d    = run_q;
    mask_d   = mask_q;
    ok_d     = ok_q;
    chosen_d = chosen_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d  = item_i;
          state_d = S_START;
        end
      end
      S_START: begin
        ok_d     = 1'b0;
        chosen_d = '0;
        mask_d   = '0;
        cursor_d = '0;
        run_d    = '0;
        at_d     = item_q.slot;
        state_d  = S_DONE;
        unique case (item_q.opcode)
          OP_CLEAR: begin
            ok_d    = 1'b1;
            state_d = S_APPLY;
          end
          OP_LOAD: begin
            ok_d     = 1'b1;
            chosen_d = item_q.slot;
            state_d  = S_APPLY;
          end
          OP_READ: begin
            ok_d     = 1'b1;
            chosen_d = item_q.slot;
          end
          OP_NATIVE: begin
            mode_d  = UM_SCAN;
            need_d  = 3'd1;
            state_d = S_WALK;
          end
          OP_FIND_RUN: begin
            mode_d  = UM_SCAN;
            need_d  = span_sz;
            state_d = S_WALK;
          end
          OP_FREE: begin
            mode_d = UM_RANGE;
            need_d = (tgt_state == SS_ANCHOR) ? span_of(tgt_size) : 3'd1;
            if (tgt_state == SS_ANCHOR || tgt_state == SS_NATIVE) begin
              ok_d     = 1'b1;
              chosen_d = item_q.slot;
              state_d  = S_WALK;
            end
          end
          OP_PLACE_AT: begin
            mode_d = UM_EVICT;
            need_d = span_sz;
            if (size_ok && aligned) begin
              state_d = S_WALK;
            end
          end
          OP_FIRST_FIT: begin
            mode_d = UM_EVICT;
            need_d = span_sz;
            at_d   = '0;
            if (size_ok) begin
              state_d = S_WALK;
            end
          end
        endcase
      end
      S_WALK: begin
        mask_d   = mask_q | unit_res.wipe;
        run_d    = unit_res.run;
        cursor_d = SlotIdxW'(cursor_q + 1'b1);
        if (unit_res.hit) begin
          ok_d     = 1'b1;
          chosen_d = unit_res.pos;
        end
        if (cursor_q == SlotIdxW'(SlotCount - 1)) begin
          state_d = (mode_q == UM_EVICT) ? S_CHECK : S_APPLY;
        end
      end
      S_CHECK: begin
        if (place_ok) begin
          ok_d     = 1'b1;
          chosen_d = at_q;
          state_d  = S_APPLY;
        end else if (item_q.opcode == OP_FIRST_FIT && more) begin
          at_d     = SlotIdxW'(next_at);
          mask_d   = '0;
          cursor_d = '0;
          state_d  = S_WALK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_APPLY: begin
        state_d = S_DONE;
        unique case (item_q.opcode)
          OP_CLEAR: cmd_o.op = TB_CLEAR;
          OP_LOAD: begin
            cmd_o.op    = TB_LOAD;
            cmd_o.slot  = item_q.slot;
            cmd_o.size  = item_q.size;
            cmd_o.state = item_q.state;
            cmd_o.base  = item_q.base;
          end
          OP_NATIVE: begin
            cmd_o.op   = ok_q ? TB_NATIVE : TB_NONE;
            cmd_o.slot = chosen_q;
          end
          OP_FREE: begin
            cmd_o.op   = TB_WIPE;
            cmd_o.mask = mask_q;
          end
          OP_PLACE_AT, OP_FIRST_FIT: begin
            cmd_o.op   = TB_PLACE;
            cmd_o.slot = at_q;
            cmd_o.size = item_q.size;
            cmd_o.base = place_base;
            cmd_o.mask = mask_q;
            cmd_o.need = need_q;
          end
          OP_FIND_RUN, OP_READ: cmd_o.op = TB_NONE;
        endcase
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ok_q     <= 1'b0;
      chosen_q <= '0;
      mode_q   <= UM_SCAN;
      cursor_q <= '0;
    end else begin
      state_q  <= state_d;
      ok_q     <= ok_d;
      chosen_q <= chosen_d;
      mode_q   <= mode_d;
      cursor_q <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    at_q   <= at_d;
    need_q <= need_d;
    run_q  <= run_d;
    mask_q <= mask_d;
  end

  assign ready_o          = (state_q == S_IDLE);
  assign done_o           = (state_q == S_DONE);
  assign res_o.ok         = ok_q;
  assign res_o.chosen     = chosen_q;
  assign res_o.base_valid = (item_q.opcode != OP_CLEAR) && (item_q.opcode != OP_FIND_RUN);

endmodule

// ===== rtl/flash_bank_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// flash_bank_slot_allocator
// Four-slot flash bank layout table with placement, eviction and free-run
// search, driven one operation per stream transaction.
// ----------------------------------------------------------------------------
// Each operation is decoded; where needed it walks every slot through the shared slot
// evaluator, checks a placement or tries first-fit candidates and issues its table
// update, then its result is registered. One item at a time, the next taken the cycle
// after its result is registered. Reset clears every slot and loads the region defaults.
module flash_bank_slot_allocator import fbsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // opcode, slot_index, size, entry_state, entry_base, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // success, chosen_slot, placed_base, read_state, read_size,
  // all_states, free_count, zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [BaseW-1:0]    cfg_data_i
);

  logic [BaseW-1:0]    region_base_q, region_base_d;
  logic [BaseW-1:0]    half_offset_q, half_offset_d;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  item_t               item;
  logic                start;
  logic                seq_ready;
  logic                seq_done;
  seq_res_t            seq_res;
  tbl_cmd_t            tbl_cmd;
  logic [StatesW-1:0]  states;
  logic [StatesW-1:0]  sizes;
  logic [BaseW-1:0]    rd_base;
  logic                out_load;

  assign item.opcode = opcode_e'(s_axis_tdata_i[2:0]);
  assign item.slot   = s_axis_tdata_i[4:3];
  assign item.size   = slot_size_e'(s_axis_tdata_i[6:5]);
  assign item.state  = slot_state_e'(s_axis_tdata_i[8:7]);
  assign item.base   = s_axis_tdata_i[32:9];

  assign s_axis_tready_o = seq_ready;
  assign start           = s_axis_tvalid_i && seq_ready;
  assign cfg_ready_o     = 1'b1;

  always_comb begin
    region_base_d = region_base_q;
    half_offset_d = half_offset_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REGION_BASE: region_base_d = cfg_data_i;
        CFG_HALF_OFFSET: half_offset_d = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= RegionBaseRst;
      half_offset_q <= HalfOffsetRst;
    end else begin
      region_base_q <= region_base_d;
      half_offset_q <= half_offset_d;
    end
  end

  fbsa_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .item_i        (item),
    .ready_o       (seq_ready),
    .states_i      (states),
    .sizes_i       (sizes),
    .region_base_i (region_base_q),
    .half_offset_i (half_offset_q),
    .cmd_o         (tbl_cmd),
    .done_o        (seq_done),
    .res_o         (seq_res),
    .take_i        (out_load)
  );

  fbsa_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tbl_cmd),
    .rd_addr_i (seq_res.chosen),
    .states_o  (states),
    .sizes_o   (sizes),
    .rd_base_o (rd_base)
  );

  assign out_load = seq_done && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    out_data_d = {6'b0,
                  count_free(states),
                  states,
                  slot_size_at(sizes, seq_res.chosen),
                  slot_state_at(states, seq_res.chosen),
                  (seq_res.ok && seq_res.base_valid) ? rd_base : BaseW'(0),
                  seq_res.chosen,
                  seq_res.ok};
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== rtl/fbsa_checker.sv =====
// ----------------------------------------------------------------------------
// fbsa_checker
// Port-level checks of the flash bank slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbsa_checker import fbsa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [StatesW-1:0] all_states;
  logic [CntW-1:0]    free_count;

  assign all_states = m_axis_tdata_o[38:31];
  assign free_count = m_axis_tdata_o[41:39];

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while an operation is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result dropped or changed");

  a_free_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> free_count == CntW'($countones({all_states[7:6] == 2'b00,
                                                        all_states[5:4] == 2'b00,
                                                        all_states[3:2] == 2'b00,
                                                        all_states[1:0] == 2'b00})))
    else $error("free count disagrees with packed slot states");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |->
      m_axis_tdata_o[2:1] == 2'b00 && m_axis_tdata_o[26:3] == 24'h0)
    else $error("failed transaction reports a slot or base");

endmodule

bind flash_bank_slot_allocator fbsa_checker u_fbsa_checker (.*);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the flash bank slot allocator. Drives table
// operations through the input stream, keeps its own copy of the slot layout
// and region registers, predicts every response and compares it field by
// field. Random gaps and stalls are applied on both stream sides. Register
// writes happen only with the table idle, across several register settings.
// ----------------------------------------------------------------------------
module tb_top import fbsa_pkg::*; ();

  localparam int HalfPeriod = 10;
  localparam int StallLimit = 2000;
  localparam int PhaseItems = 300;
  localparam int PhaseCount = 6;

  typedef struct {
    opcode_e          op;
    logic [1:0]       slot;
    slot_size_e       size;
    slot_state_e      state;
    logic [BaseW-1:0] base;
  } request_t;

  typedef struct {
    logic             ok;
    logic [1:0]       slot;
    logic [BaseW-1:0] base;
    slot_state_e      state;
    slot_size_e       size;
    logic [7:0]       states;
    logic [2:0]       nfree;
  } outcome_t;

  class layout_scoreboard;
    slot_state_e      st[SlotCount];
    slot_size_e       sz[SlotCount];
    logic [BaseW-1:0] bs[SlotCount];
    logic [BaseW-1:0] region_base;
    logic [BaseW-1:0] half_offset;
    outcome_t         expected_outcomes[$];
    int               errors;

    function new();
      region_base = RegionBaseRst;
      half_offset = HalfOffsetRst;
      errors = 0;
      for (int i = 0; i < SlotCount; i++) wipe(i);
    endfunction

    function void set_register(cfg_idx_e idx, logic [BaseW-1:0] v);
      if (idx == CFG_REGION_BASE) region_base = v;
      else half_offset = v;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    function void wipe(int i);
      st[i] = SS_FREE;
      sz[i] = SZ_256K;
      bs[i] = '0;
    endfunction

    function int run_len(slot_size_e c);
      if (c == SZ_1M) return 4;
      if (c == SZ_512K) return 2;
      return 1;
    endfunction

    function int first_free_run(int need);
      bit clear_run;
      for (int i = 0; i + need <= SlotCount; i++) begin
        clear_run = 1'b1;
        for (int j = 0; j < need; j++) if (st[i+j] != SS_FREE) clear_run = 1'b0;
        if (clear_run) return i;
      end
      return -1;
    endfunction

    function bit release_slot(int s);
      int n;
      if (st[s] == SS_ANCHOR) begin
        n = run_len(sz[s]);
        for (int j = 0; j < n && s + j < SlotCount; j++) wipe(s + j);
        return 1'b1;
      end
      if (st[s] == SS_NATIVE) begin
        wipe(s);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void evict(int at, int need);
      int hi;
      for (int i = 0; i < SlotCount; i++) begin
        if (st[i] == SS_ANCHOR) begin
          hi = i + run_len(sz[i]);
          if (i < at + need && at < hi) void'(release_slot(i));
        end else if (st[i] == SS_NATIVE) begin
          if (i >= at && i < at + need) void'(release_slot(i));
        end
      end
    endfunction

    function bit can_place(int s, slot_size_e c);
      slot_state_e      st_keep[SlotCount];
      slot_size_e       sz_keep[SlotCount];
      logic [BaseW-1:0] bs_keep[SlotCount];
      int               need;
      bit               fits;
      need = run_len(c);
      fits = 1'b1;
      if (s + need > SlotCount) return 1'b0;
      if (c == SZ_512K && s[0]) return 1'b0;
      if (c == SZ_1M && s != 0) return 1'b0;
      st_keep = st;
      sz_keep = sz;
      bs_keep = bs;
      evict(s, need);
      for (int j = 0; j < need; j++) if (st[s+j] != SS_FREE) fits = 1'b0;
      if (c == SZ_1M)
        for (int j = 0; j < SlotCount; j++) if (st[j] != SS_FREE) fits = 1'b0;
      st = st_keep;
      sz = sz_keep;
      bs = bs_keep;
      return fits;
    endfunction

    function bit place(int s, slot_size_e c);
      int               need;
      logic [BaseW-1:0] anchor_base;
      need = run_len(c);
      anchor_base = region_base;
      if (c != SZ_512K && c != SZ_1M) return 1'b0;
      if (!can_place(s, c)) return 1'b0;
      evict(s, need);
      if (c == SZ_512K && s >= 2) anchor_base = region_base + half_offset;
      st[s] = SS_ANCHOR;
      sz[s] = c;
      bs[s] = anchor_base;
      for (int j = 1; j < need; j++) begin
        st[s+j] = SS_SHADOW;
        sz[s+j] = SZ_256K;
        bs[s+j] = '0;
      end
      return 1'b1;
    endfunction

    function void note_request(request_t r);
      outcome_t o;
      bit       base_valid;
      int       pick;
      int       chosen;
      o.ok = 1'b0;
      base_valid = 1'b1;
      chosen = 0;
      case (r.op)
        OP_CLEAR: begin
          for (int i = 0; i < SlotCount; i++) wipe(i);
          o.ok = 1'b1;
          base_valid = 1'b0;
        end
        OP_LOAD: begin
          st[r.slot] = r.state;
          sz[r.slot] = r.size;
          bs[r.slot] = r.base;
          if (r.state == SS_NATIVE) begin
            sz[r.slot] = SZ_256K;
            bs[r.slot] = {4'd0, r.slot, 18'd0};
          end
          o.ok = 1'b1;
          chosen = r.slot;
        end
        OP_NATIVE: begin
          pick = first_free_run(1);
          if (pick >= 0) begin
            st[pick] = SS_NATIVE;
            sz[pick] = SZ_256K;
            bs[pick] = {4'd0, 2'(pick), 18'd0};
            o.ok = 1'b1;
            chosen = pick;
          end
        end
        OP_PLACE_AT: begin
          if (place(r.slot, r.size)) begin
            o.ok = 1'b1;
            chosen = r.slot;
          end
        end
        OP_FIRST_FIT: begin
          if (r.size == SZ_512K || r.size == SZ_1M) begin
            for (int i = 0; i + run_len(r.size) <= SlotCount && !o.ok; i++) begin
              if (place(i, r.size)) begin
                o.ok = 1'b1;
                chosen = i;
              end
            end
          end
        end
        OP_FREE: begin
          if (release_slot(r.slot)) begin
            o.ok = 1'b1;
            chosen = r.slot;
          end
        end
        OP_FIND_RUN: begin
          pick = first_free_run(run_len(r.size));
          if (pick >= 0) begin
            o.ok = 1'b1;
            chosen = pick;
          end
          base_valid = 1'b0;
        end
        default: begin
          o.ok = 1'b1;
          chosen = r.slot;
        end
      endcase
      o.states = '0;
      o.nfree = '0;
      for (int i = 0; i < SlotCount; i++) begin
        o.states[2*i +: 2] = st[i];
        if (st[i] == SS_FREE) o.nfree++;
      end
      o.slot = 2'(chosen);
      o.base = (o.ok && base_valid) ? bs[chosen] : '0;
      o.state = st[chosen];
      o.size = sz[chosen];
      expected_outcomes.push_back(o);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t mismatch %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(logic [OutDataW-1:0] d);
      outcome_t o;
      if (expected_outcomes.size() == 0) begin
        $display("%0t unexpected response: expected none, actual 0x%0h", $time, d);
        errors++;
        return;
      end
      o = expected_outcomes.pop_front();
      compare_field("success", o.ok, d[0]);
      compare_field("chosen_slot", o.slot, d[2:1]);
      compare_field("placed_base", o.base, d[26:3]);
      compare_field("read_state", o.state, d[28:27]);
      compare_field("read_size", o.size, d[30:29]);
      compare_field("all_states", o.states, d[38:31]);
      compare_field("free_count", o.nfree, d[41:39]);
      compare_field("pad", 0, d[47:42]);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [BaseW-1:0]    cfg_data_i;

  layout_scoreboard sb = new();
  bit               calm = 1'b0;

  flash_bank_slot_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  function automatic request_t req(opcode_e op, int slot, slot_size_e size,
                                   slot_state_e state, logic [BaseW-1:0] base);
    request_t r;
    r.op = op;
    r.slot = 2'(slot);
    r.size = size;
    r.state = state;
    r.base = base;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       roll;
    roll = $urandom_range(0, 99);
    r = req(OP_READ, $urandom_range(0, 3), slot_size_e'($urandom_range(0, 3)),
            slot_state_e'($urandom_range(0, 3)), BaseW'($urandom));
    if (roll < 12) r.op = OP_LOAD;
    else if (roll < 27) r.op = OP_NATIVE;
    else if (roll < 47) r.op = OP_PLACE_AT;
    else if (roll < 62) r.op = OP_FIRST_FIT;
    else if (roll < 80) r.op = OP_FREE;
    else if (roll < 89) r.op = OP_FIND_RUN;
    else if (roll < 97) r.op = OP_READ;
    else r.op = OP_CLEAR;
    if ((r.op == OP_PLACE_AT || r.op == OP_FIRST_FIT) && $urandom_range(0, 4) != 0)
      r.size = $urandom_range(0, 1) ? SZ_512K : SZ_1M;
    return r;
  endfunction

  task automatic send_request(request_t r, int gap);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, r.base, r.state, r.size, r.slot, r.op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(r);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [BaseW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // response side: check and apply random backpressure
  initial begin
    int hold;
    int roll;
    hold = 0;
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_response(m_axis_tdata_o);
      if (hold > 0) begin
        hold--;
      end else if (calm) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          m_axis_tready_i <= 1'b1;
          hold = $urandom_range(0, 6);
        end else if (roll < 92) begin
          m_axis_tready_i <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          m_axis_tready_i <= 1'b0;
          hold = $urandom_range(10, 50);
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    request_t         directed[$];
    logic [BaseW-1:0] base_val;
    logic [BaseW-1:0] half_val;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_REGION_BASE;
    cfg_data_i      <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      req(OP_READ,      3, SZ_256K, SS_FREE,   24'h000000),
      req(OP_FIND_RUN,  0, SZ_1M,   SS_FREE,   24'h000000),
      req(OP_NATIVE,    0, SZ_256K, SS_FREE,   24'h000000),
      req(OP_NATIVE,    0, SZ_256K, SS_FREE,   24'h000000),
      req(OP_PLACE_AT,  1, SZ_512K, SS_FREE,   24'h000000),
      req(OP_PLACE_AT,  2, SZ_1M,   SS_FREE,   24'h000000),
      req(OP_PLACE_AT,  2, SZ_256K, SS_FREE,   24'h000000),
      req(OP_FIRST_FIT, 0, SZ_ODD,  SS_FREE,   24'h000000),
      req(OP_PLACE_AT,  2, SZ_512K, SS_FREE,   24'h000000),
      req(OP_FIND_RUN,  0, SZ_256K, SS_FREE,   24'h000000),
      req(OP_FIRST_FIT, 0, SZ_1M,   SS_FREE,   24'h000000),
      req(OP_FREE,      1, SZ_256K, SS_FREE,   24'h000000),
      req(OP_FREE,      0, SZ_256K, SS_FREE,   24'h000000),
      req(OP_FREE,      2, SZ_256K, SS_FREE,   24'h000000),
      req(OP_LOAD,      3, SZ_ODD,  SS_NATIVE, 24'hFFFFFF),
      req(OP_LOAD,      1, SZ_ODD,  SS_SHADOW, 24'hFFFFFF),
      req(OP_PLACE_AT,  0, SZ_512K, SS_FREE,   24'h000000),
      req(OP_FIRST_FIT, 0, SZ_512K, SS_FREE,   24'h000000),
      req(OP_LOAD,      2, SZ_1M,   SS_ANCHOR, 24'h123456),
      req(OP_FREE,      2, SZ_256K, SS_FREE,   24'h000000),
      req(OP_LOAD,      0, SZ_ODD,  SS_ANCHOR, 24'hFFFFFF),
      req(OP_FREE,      0, SZ_256K, SS_FREE,   24'h000000),
      req(OP_CLEAR,     0, SZ_256K, SS_FREE,   24'h000000)
    };
    foreach (directed[i]) send_request(directed[i], pick_gap());
    drain();
    write_register(CFG_REGION_BASE, 24'hFFFFFF);
    write_register(CFG_HALF_OFFSET, 24'hFFFFFF);
    send_request(req(OP_PLACE_AT, 2, SZ_512K, SS_FREE, 24'h000000), pick_gap());
    send_request(req(OP_PLACE_AT, 0, SZ_512K, SS_FREE, 24'h000000), pick_gap());

    for (int p = 0; p < PhaseCount; p++) begin
      drain();
      case (p)
        0: begin
          base_val = '0;
          half_val = '0;
        end
        1: begin
          base_val = 24'hFFFFFF;
          half_val = 24'hFFFFFF;
        end
        2: begin
          base_val = RegionBaseRst;
          half_val = HalfOffsetRst;
        end
        default: begin
          base_val = BaseW'($urandom);
          half_val = BaseW'($urandom);
        end
      endcase
      write_register(CFG_HALF_OFFSET, half_val);
      write_register(CFG_REGION_BASE, base_val);
      calm = (p == 2);
      for (int k = 0; k < PhaseItems; k++) send_request(random_request(), pick_gap());
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
